/* src/assert_macros.svh */
// Assertion helpers used by the checker file sat_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define SAT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sat: property violated");

// Clocked property that is also checked during reset.
`define SAT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sat: property violated in or out of reset");

`endif

/* src/sat_pkg.sv */
package sat_pkg;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_ADD_BOTH = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;
  localparam logic [1:0] RST_SKIP   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] node;
    logic [7:0] neighbor;
    logic [4:0] position;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [1:0] reverse_status;
    logic [5:0] list_length;
    logic [7:0] entry;
  } out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_LEN_RD,
    DP_SRCH_RD,
    DP_SRCH_UPD,
    DP_HIT_RD,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_INS_WR,
    DP_POS_RD,
    DP_FIN_RD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   rev;   // work on the neighbor's row, keyed by node
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       clr_done;
    logic       row_ok;
    logic       srch_more;
    logic       hit;
    logic       full;
    logic       shift_more;
    logic       pos_ok;
  } stat_t;

endpackage

/* src/sat_datapath.sv */
module sat_datapath #(
  parameter int NODES      = 256,
  parameter int MAX_DEGREE = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sat_pkg::in_t  in_data_i,
  input  sat_pkg::cmd_t cmd_i,
  output sat_pkg::stat_t stat_o,
  output logic [7:0]    entry_o,
  output logic [5:0]    length_o
);

  localparam int RowW = $clog2(NODES);
  localparam int ColW = (MAX_DEGREE > 2) ? $clog2(MAX_DEGREE) : 1;
  localparam int LenW = $clog2(MAX_DEGREE + 1);

  logic [7:0]      nmem [NODES][MAX_DEGREE];
  logic [LenW-1:0] lmem [NODES];

  sat_pkg::in_t    item_q;
  logic [RowW-1:0] clr_cnt_q;
  logic [LenW-1:0] lo_q, hi_q, len_q, idx_q, length_q;
  logic [7:0]      rd_q, entry_q;

  logic [7:0]      row_sel, key;
  logic [RowW-1:0] row, node_row;
  logic            row_ok, node_ok;
  logic [LenW-1:0] mid;

  assign row_sel  = cmd_i.rev ? item_q.neighbor : item_q.node;
  assign key      = cmd_i.rev ? item_q.node : item_q.neighbor;
  assign row      = RowW'(row_sel);
  assign node_row = RowW'(item_q.node);
  assign row_ok   = 32'(row_sel) < NODES;
  assign node_ok  = 32'(item_q.node) < NODES;
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.op == sat_pkg::DP_CLR) begin
      clr_cnt_q <= clr_cnt_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sat_pkg::DP_CLR: lmem[clr_cnt_q] <= '0;
      sat_pkg::DP_LOAD: begin
        item_q  <= in_data_i;
        entry_q <= '0;
      end
      sat_pkg::DP_LEN_RD: begin
        len_q <= lmem[row];
        hi_q  <= lmem[row];
        lo_q  <= '0;
      end
      sat_pkg::DP_SRCH_RD: rd_q <= nmem[row][ColW'(mid)];
      sat_pkg::DP_SRCH_UPD: begin
        if (rd_q < key) begin
          lo_q <= mid + LenW'(1);
        end else begin
          hi_q <= mid;
        end
      end
      sat_pkg::DP_HIT_RD: begin
        rd_q  <= nmem[row][ColW'(lo_q)];
        idx_q <= len_q;
      end
      sat_pkg::DP_SHIFT_RD: rd_q <= nmem[row][ColW'(idx_q - LenW'(1))];
      sat_pkg::DP_SHIFT_WR: begin
        nmem[row][ColW'(idx_q)] <= rd_q;
        idx_q <= idx_q - LenW'(1);
      end
      sat_pkg::DP_INS_WR: begin
        nmem[row][ColW'(lo_q)] <= key;
        lmem[row] <= len_q + LenW'(1);
      end
      sat_pkg::DP_POS_RD: entry_q <= nmem[row][ColW'(item_q.position)];
      sat_pkg::DP_FIN_RD: length_q <= node_ok ? lmem[node_row] : '0;
      default: ;
    endcase
  end

  always_comb begin
    stat_o.mode       = item_q.mode;
    stat_o.clr_done   = clr_cnt_q == RowW'(NODES - 1);
    stat_o.row_ok     = row_ok;
    stat_o.srch_more  = lo_q < hi_q;
    stat_o.hit        = (lo_q < len_q) && (rd_q == key);
    stat_o.full       = 32'(len_q) >= MAX_DEGREE;
    stat_o.shift_more = idx_q > lo_q;
    stat_o.pos_ok     = 32'(item_q.position) < 32'(len_q);
  end

  assign entry_o  = entry_q;
  assign length_o = 6'(length_q);

endmodule

/* src/sat_ctrl.sv */
module sat_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  sat_pkg::stat_t stat_i,
  output sat_pkg::cmd_t  cmd_o,
  output logic [1:0]     status_o,
  output logic           found_o,
  output logic [1:0]     rstatus_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_SRCH, S_SUPD, S_HIT,
    S_SHIFT, S_SHWR, S_POS, S_FIN, S_OUT
  } state_e;

  state_e     state_q;
  logic       rev_q;
  logic [1:0] status_q, rstatus_q;
  logic       found_q;

  logic       ins_end;
  logic [1:0] ins_code;
  logic       is_add;

  assign is_add = (stat_i.mode == sat_pkg::MODE_ADD) || (stat_i.mode == sat_pkg::MODE_ADD_BOTH);

  always_comb begin
    cmd_o.op  = sat_pkg::DP_NOP;
    cmd_o.rev = rev_q;
    ins_end   = 1'b0;
    ins_code  = sat_pkg::ST_OK;
    unique case (state_q)
      S_CLR:  cmd_o.op = sat_pkg::DP_CLR;
      S_IDLE: if (in_valid_i) cmd_o.op = sat_pkg::DP_LOAD;
      S_START: begin
        if (stat_i.row_ok) begin
          cmd_o.op = sat_pkg::DP_LEN_RD;
        end else if (is_add) begin
          ins_end  = 1'b1;
          ins_code = sat_pkg::ST_FULL;
        end
      end
      S_SRCH: cmd_o.op = stat_i.srch_more ? sat_pkg::DP_SRCH_RD : sat_pkg::DP_HIT_RD;
      S_SUPD: cmd_o.op = sat_pkg::DP_SRCH_UPD;
      S_HIT: begin
        if (is_add && stat_i.hit) begin
          ins_end  = 1'b1;
          ins_code = sat_pkg::ST_PRESENT;
        end else if (is_add && stat_i.full) begin
          ins_end  = 1'b1;
          ins_code = sat_pkg::ST_FULL;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.op = sat_pkg::DP_SHIFT_RD;
        end else begin
          cmd_o.op = sat_pkg::DP_INS_WR;
          ins_end  = 1'b1;
        end
      end
      S_SHWR: cmd_o.op = sat_pkg::DP_SHIFT_WR;
      S_POS:  if (stat_i.pos_ok) cmd_o.op = sat_pkg::DP_POS_RD;
      S_FIN:  cmd_o.op = sat_pkg::DP_FIN_RD;
      S_OUT:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      rev_q     <= 1'b0;
      status_q  <= sat_pkg::ST_OK;
      found_q   <= 1'b0;
      rstatus_q <= sat_pkg::RST_SKIP;
    end else if (ins_end) begin
      // an insert finished: forward result may trigger the reverse insert
      if (!rev_q) begin
        status_q <= ins_code;
        if (stat_i.mode == sat_pkg::MODE_ADD_BOTH && ins_code == sat_pkg::ST_OK) begin
          rev_q   <= 1'b1;
          state_q <= S_START;
        end else begin
          state_q <= S_FIN;
        end
      end else begin
        rstatus_q <= ins_code;
        state_q   <= S_FIN;
      end
    end else begin
      unique case (state_q)
        S_CLR: if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE: begin
          if (in_valid_i) begin
            rev_q     <= 1'b0;
            status_q  <= sat_pkg::ST_OK;
            found_q   <= 1'b0;
            rstatus_q <= sat_pkg::RST_SKIP;
            state_q   <= S_START;
          end
        end
        S_START: begin
          if (!rev_q && stat_i.mode == sat_pkg::MODE_READ) begin
            if (stat_i.row_ok) begin
              state_q <= S_POS;
            end else begin
              status_q <= sat_pkg::ST_RANGE;
              state_q  <= S_FIN;
            end
          end else if (stat_i.row_ok) begin
            state_q <= S_SRCH;
          end else begin
            state_q <= S_FIN;   // query on a missing row: not found
          end
        end
        S_SRCH: state_q <= stat_i.srch_more ? S_SUPD : S_HIT;
        S_SUPD: state_q <= S_SRCH;
        S_HIT: begin
          if (is_add) begin
            state_q <= S_SHIFT;
          end else begin
            found_q <= stat_i.hit;
            state_q <= S_FIN;
          end
        end
        S_SHIFT: state_q <= S_SHWR;
        S_SHWR:  state_q <= S_SHIFT;
        S_POS: begin
          if (!stat_i.pos_ok) status_q <= sat_pkg::ST_RANGE;
          state_q <= S_FIN;
        end
        S_FIN: state_q <= S_OUT;
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign rstatus_o   = rstatus_q;

endmodule

/* src/sorted_adjacency_table.sv */
// Channel  Direction  Valid        Stall        Payload
// input    in         in_valid_i   in_stall_o   in_data_i   (sat_pkg::in_t)
// result   out        out_valid_o  out_stall_i  out_data_o  (sat_pkg::out_t)
//
// One item at a time: a read looks up one entry of the row by its position; a query, or an add
// that finds the neighbor present or the list full, does a binary search of the row; an add that
// writes also moves the later entries up one place each, then inserts; both ways adds reverse pass.
// After reset a clearing pass zeroes the length table; input stalls meanwhile.
// The result holds in its register while out_stall_i is high; input stalls meanwhile.
module sorted_adjacency_table #(
  parameter int NODES      = 256,
  parameter int MAX_DEGREE = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sat_pkg::out_t out_data_o
);

  sat_pkg::cmd_t  cmd;
  sat_pkg::stat_t stat;
  logic [7:0]     entry;
  logic [5:0]     length;
  logic [1:0]     status, rstatus;
  logic           found;

  sat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .status_o    (status),
    .found_o     (found),
    .rstatus_o   (rstatus)
  );

  sat_datapath #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .entry_o   (entry),
    .length_o  (length)
  );

  always_comb begin
    out_data_o.status         = status;
    out_data_o.found          = found;
    out_data_o.reverse_status = rstatus;
    out_data_o.list_length    = length;
    out_data_o.entry          = entry;
  end

endmodule

/* src/sat_checker.sv */
`include "assert_macros.svh"

module sat_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input sat_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input sat_pkg::out_t out_data_o
);

  // stalled result holds
  `SAT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // one item in flight: no new input while a result waits
  `SAT_ASSERT(a_one_item, clk_i, rst_ni, out_valid_o |-> in_stall_o)

  // a transfer in never produces its result in the next cycle
  `SAT_ASSERT(a_no_instant, clk_i, rst_ni, in_valid_i && !in_stall_o |=> !out_valid_o)

  // a found flag only comes from a query
  `SAT_ASSERT(a_found_query, clk_i, rst_ni, out_valid_o && out_data_o.found |-> out_data_o.status == sat_pkg::ST_OK && out_data_o.reverse_status == sat_pkg::RST_SKIP && out_data_o.entry == 8'd0)

  // nothing moves while reset is held
  `SAT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && in_stall_o)

endmodule

bind sorted_adjacency_table sat_checker u_sat_checker (.*);
